// ===== rtl/mmgn_pkg.sv =====
// Shared types and constants for the min/max gray normaliser.
// No dependencies; imported by the front end, the divider and the top level.
package mmgn_pkg;

	// Default sample width (signed Q16.16)
	localparam int unsigned DEF_SAMPLE_WIDTH = 32;

	// Width of one gray level; also the number of quotient bits after the range check
	localparam int unsigned GRAY_WIDTH = 8;

	// Depth of the queue between front end and divider
	localparam int unsigned QUEUE_DEPTH = 4;

	// Request type codes
	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	// Divider sequencer states
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RANGE,
		DIV_STEP,
		DIV_OUT
	} div_state_t;

endpackage

// ===== rtl/mmgn_queue.sv =====
// Small register queue that decouples the front end from the divider.
// Does not depend on mmgn_pkg; fully parameterised.
module mmgn_queue #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue occupancy out of range");

endmodule

// ===== rtl/mmgn_front.sv =====
// Front end: accepts transactions, tracks field minimum and maximum,
// and queues the offset and range of each convert sample. Uses mmgn_pkg.
module mmgn_front #(
	parameter int unsigned SAMPLE_WIDTH = mmgn_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           first,
	input  logic                           last,
	input  logic                           q_full,
	output logic                           q_push,
	output logic        [SAMPLE_WIDTH-1:0] q_diff,
	output logic        [SAMPLE_WIDTH-1:0] q_range,
	output logic                           q_last
);

	import mmgn_pkg::*;

	localparam logic [SAMPLE_WIDTH-1:0] MAX_POS = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] MAX_NEG = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic        [SAMPLE_WIDTH:0]   diff;
	logic        [SAMPLE_WIDTH:0]   span;
	logic                           fire;
	logic                           diff_pos;
	logic                           span_pos;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	// Offset from minimum and span of the field, one bit wider to stay exact
	assign diff = {sample[SAMPLE_WIDTH-1], sample} - {min_q[SAMPLE_WIDTH-1], min_q};
	assign span = {max_q[SAMPLE_WIDTH-1], max_q} - {min_q[SAMPLE_WIDTH-1], min_q};

	assign diff_pos = !diff[SAMPLE_WIDTH] && (diff != '0);
	assign span_pos = !span[SAMPLE_WIDTH] && (span != '0);

	// Clip offset at zero and force a flat field to a range of one LSB
	assign q_push  = fire && (req_type == REQ_CONVERT);
	assign q_diff  = diff_pos ? diff[SAMPLE_WIDTH-1:0] : '0;
	assign q_range = span_pos ? span[SAMPLE_WIDTH-1:0] : SAMPLE_WIDTH'(1);
	assign q_last  = last;

	// Track minimum and maximum over measure transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MAX_POS;
			max_q <= MAX_NEG;
		end else if (fire && (req_type == REQ_MEASURE)) begin
			if (first) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
		end
	end

	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_type == REQ_MEASURE) && first) |=> (min_q == max_q))
		else $error("first sample did not restart tracking");

	a_measure_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_type == REQ_MEASURE)) |-> !q_push)
		else $error("measure transaction reached the queue");

	a_range_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_range != '0)) else $error("zero range queued");

endmodule

// ===== rtl/mmgn_divider.sv =====
// Back end: restoring divider that turns offset*255/range into a gray level
// and holds it in the output register. Uses mmgn_pkg.
module mmgn_divider #(
	parameter int unsigned SAMPLE_WIDTH = mmgn_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	output logic                                  q_pop,
	input  logic        [SAMPLE_WIDTH-1:0]        q_diff,
	input  logic        [SAMPLE_WIDTH-1:0]        q_range,
	input  logic                                  q_last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [mmgn_pkg::GRAY_WIDTH-1:0] gray,
	output logic                                  end_of_frame
);

	import mmgn_pkg::*;

	localparam int unsigned NUM_W = SAMPLE_WIDTH + GRAY_WIDTH;
	localparam int unsigned CNT_W = $clog2(GRAY_WIDTH);

	div_state_t             state_q;
	div_state_t             state_d;
	logic [NUM_W-1:0]       num_q;
	logic [NUM_W-1:0]       den_q;
	logic [GRAY_WIDTH-1:0]  quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   last_q;
	logic                   num_ge_den;
	logic                   load_out;

	assign num_ge_den = (num_q >= den_q);

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: pop, range check, one quotient bit a cycle, hand over
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = DIV_RANGE;
				end
			end
			DIV_RANGE: begin
				state_d = num_ge_den ? DIV_OUT : DIV_STEP;
			end
			DIV_STEP: begin
				if (cnt_q == '0) begin
					state_d = DIV_OUT;
				end
			end
			DIV_OUT: begin
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d  = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == DIV_RANGE) begin
			cnt_q <= CNT_W'(GRAY_WIDTH - 1);
		end else if (state_q == DIV_STEP) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Divider datapath: numerator is offset*255, divisor starts at range<<8
	always_ff @(posedge clk) begin
		if (q_pop) begin
			num_q  <= {q_diff, {GRAY_WIDTH{1'b0}}} - {{GRAY_WIDTH{1'b0}}, q_diff};
			den_q  <= {q_range, {GRAY_WIDTH{1'b0}}};
			last_q <= q_last;
		end else if (state_q == DIV_RANGE) begin
			// Saturate when the quotient would exceed the gray range
			if (num_ge_den) begin
				quo_q <= '1;
			end else begin
				den_q <= den_q >> 1;
			end
		end else if (state_q == DIV_STEP) begin
			if (num_ge_den) begin
				num_q <= num_q - den_q;
			end
			quo_q <= {quo_q[GRAY_WIDTH-2:0], num_ge_den};
			den_q <= den_q >> 1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			gray         <= quo_q;
			end_of_frame <= last_q;
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == DIV_IDLE)) else $error("pop while dividing");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_STEP) |-> ({1'b0, num_q} < {den_q, 1'b0}))
		else $error("partial remainder out of bound");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid || out_ready)) else $error("result overwritten");

	a_range_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == DIV_RANGE) && num_ge_den) |=> (state_q == DIV_OUT))
		else $error("saturated result not handed over");

endmodule

// ===== rtl/min_max_gray_normalizer_core.sv =====
// Top level of the min/max gray normaliser: front end, queue and divider.
// Depends on mmgn_pkg, mmgn_front, mmgn_queue and mmgn_divider.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  in      | in_valid / in_ready | req_type, sample, first, last
//  out     | out_valid/out_ready | gray, end_of_frame
//
// Measure transactions are taken one per cycle while the queue is not full and
// update min/max at once. In the divider a convert transaction passes pop, range
// check, eight restoring steps and hand-over; a saturating one skips the steps.
// A four-entry queue holds convert transactions; in_ready drops while it is full.
// Asynchronous reset sets min to the most positive and max to the most negative value.
// The output register takes a new result while or after the previous one is taken.
module min_max_gray_normalizer_core #(
	parameter int unsigned SAMPLE_WIDTH = mmgn_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	input  logic                                  first,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [mmgn_pkg::GRAY_WIDTH-1:0] gray,
	output logic                                  end_of_frame
);

	import mmgn_pkg::*;

	localparam int unsigned ENTRY_W = 2 * SAMPLE_WIDTH + 1;

	logic                    q_full;
	logic                    q_empty;
	logic                    q_push;
	logic                    q_pop;
	logic [SAMPLE_WIDTH-1:0] push_diff;
	logic [SAMPLE_WIDTH-1:0] push_range;
	logic                    push_last;
	logic [ENTRY_W-1:0]      push_entry;
	logic [ENTRY_W-1:0]      pop_entry;

	assign push_entry = {push_last, push_range, push_diff};

	// Accept and classify transactions
	mmgn_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.sample  (sample),
		.first   (first),
		.last    (last),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_diff  (push_diff),
		.q_range (push_range),
		.q_last  (push_last)
	);

	// Buffer convert transactions
	mmgn_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_entry),
		.empty    (q_empty)
	);

	// Divide and deliver
	mmgn_divider #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_divider (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_diff      (pop_entry[SAMPLE_WIDTH-1:0]),
		.q_range     (pop_entry[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.q_last      (pop_entry[ENTRY_W-1]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.gray        (gray),
		.end_of_frame(end_of_frame)
	);

endmodule
